@@ rtl/bba_pkg.sv @@
// shared types and constants of the first-fit block bitmap allocator
// no dependencies; imported by block_bitmap_allocator_top
`default_nettype none

package bba_pkg;

	// fixed field widths
	localparam int CFG_W     = 13;
	localparam int BLK_W     = 12;
	localparam int CFG_IDX_W = 1;

	// parameter defaults
	localparam int DEF_NUM_BLOCKS    = 4096;
	localparam int DEF_MAP_WORD_BITS = 32;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 1'd1;
	localparam logic [CFG_W-1:0]     RST_FIRST_DATA = 13'd0;
	localparam logic [CFG_W-1:0]     RST_TOTAL      = 13'd4096;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic             kind;
		logic [BLK_W-1:0] blk_idx;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] granted_block;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/block_bitmap_allocator_top.sv @@
// channel   | direction | handshake            | payload
// req       | in        | req_valid/req_ready  | req_t (kind, blk_idx)
// rsp       | out       | rsp_valid/rsp_ready  | rsp_t (status, granted_block)
// cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a free reads its bitmap word on accept, then clears the bit and gives its result in S_FREE;
// an allocate reads the window word by word in S_SCAN, set by the single read port of the map memory
// an out-of-range free or an empty scan window has its result decided in the accept cycle, with no scan
// after reset a clearing pass writes zeros to every map word, with req_ready low
// a result waiting in the output register does not block the next item; a second
// finished result waits in a holding register until the first is taken
// cfg_ready is always high
// depends on bba_pkg; MAP_WORD_BITS must be a power of two
`default_nettype none

module block_bitmap_allocator_top
	import bba_pkg::*;
#(
	parameter int NUM_BLOCKS    = DEF_NUM_BLOCKS,
	parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int MAP_DEPTH = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int OFF_W     = $clog2(MAP_WORD_BITS);
	localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int BW        = AW + OFF_W;
	localparam int LW        = (BW + 1 > CFG_W) ? BW + 1 : CFG_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FREE  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]               state_q;
	logic [CFG_W-1:0]         first_q;
	logic [CFG_W-1:0]         total_q;
	logic [AW-1:0]            clr_q;
	logic [AW-1:0]            wp_q;
	logic [OFF_W-1:0]         off_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	rsp_t                     hold_q;

	logic [MAP_WORD_BITS-1:0] map_mem [MAP_DEPTH];
	logic [MAP_WORD_BITS-1:0] map_rd_q;
	logic                     mem_we;
	logic [AW-1:0]            mem_wa;
	logic [MAP_WORD_BITS-1:0] mem_wd;
	logic [AW-1:0]            mem_ra;

	logic [LW-1:0]            total_x;
	logic [LW-1:0]            nb_x;
	logic [LW-1:0]            limit;
	logic [LW-1:0]            first_x;
	logic [LW-1:0]            last_x;
	logic [LW-1:0]            id_x;
	logic [AW-1:0]            first_w;
	logic [OFF_W-1:0]         first_o;
	logic [AW-1:0]            last_w;
	logic [OFF_W-1:0]         last_o;
	logic                     scan_empty;
	logic                     id_bad;
	logic                     req_fire;

	logic [OFF_W-1:0]         lo_off;
	logic [OFF_W-1:0]         hi_off;
	logic [MAP_WORD_BITS-1:0] cand;
	logic                     hit;
	logic [OFF_W-1:0]         hit_off;
	logic [LW-1:0]            blk_x;

	logic                     res_en;
	rsp_t                     res;
	logic                     slot_free;
	logic [2:0]               next_after;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid & req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= RST_FIRST_DATA;
			total_q <= RST_TOTAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FIRST_DATA: first_q <= cfg_data;
				REG_TOTAL:      total_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// effective block count and scan window
	always_comb begin
		total_x    = LW'(total_q);
		nb_x       = LW'(NUM_BLOCKS);
		limit      = (total_x < nb_x) ? total_x : nb_x;
		first_x    = LW'(first_q);
		last_x     = limit - LW'(1);
		id_x       = LW'(req.blk_idx);
		first_w    = first_x[OFF_W +: AW];
		first_o    = first_x[OFF_W-1:0];
		last_w     = last_x[OFF_W +: AW];
		last_o     = last_x[OFF_W-1:0];
		scan_empty = (first_x >= limit);
		id_bad     = (id_x >= limit);
	end

	// first clear bit of the current word inside the window
	always_comb begin
		lo_off  = (wp_q == first_w) ? first_o : '0;
		hi_off  = (wp_q == last_w) ? last_o : OFF_W'(MAP_WORD_BITS - 1);
		hit     = 1'b0;
		hit_off = '0;
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			cand[j] = !map_rd_q[j] && (OFF_W'(j) >= lo_off) && (OFF_W'(j) <= hi_off);
		end
		for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
			if (cand[j]) begin
				hit     = 1'b1;
				hit_off = OFF_W'(j);
			end
		end
		blk_x = LW'({wp_q, hit_off});
	end

	// memory port control and result generation
	always_comb begin
		mem_we         = 1'b0;
		mem_wa         = wp_q;
		mem_wd         = map_rd_q;
		mem_ra         = wp_q;
		res_en         = 1'b0;
		res.status     = STAT_DONE;
		res.granted_block = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			S_IDLE: begin
				if (req_fire) begin
					if (req.kind == KIND_FREE) begin
						mem_ra = id_x[OFF_W +: AW];
						if (id_bad) begin
							res_en     = 1'b1;
							res.status = STAT_RANGE;
						end
					end else begin
						mem_ra = first_w;
						if (scan_empty) begin
							res_en     = 1'b1;
							res.status = STAT_FULL;
						end
					end
				end
			end
			S_FREE: begin
				mem_we = 1'b1;
				mem_wd = map_rd_q & ~(MAP_WORD_BITS'(1) << off_q);
				res_en = 1'b1;
			end
			S_SCAN: begin
				mem_ra = wp_q + AW'(1);
				if (hit) begin
					mem_we            = 1'b1;
					mem_wd            = map_rd_q | (MAP_WORD_BITS'(1) << hit_off);
					res_en            = 1'b1;
					res.granted_block = blk_x[BLK_W-1:0];
				end else if (wp_q == last_w) begin
					res_en     = 1'b1;
					res.status = STAT_FULL;
				end
			end
			default: ;
		endcase
		next_after = slot_free ? S_IDLE : S_RESP;
	end

	// bitmap memory; every write outside the clearing pass ends an item, so the next read never overlaps it
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		map_rd_q <= map_mem[mem_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (res_en) begin
						state_q <= next_after;
					end else if (req_fire) begin
						state_q <= (req.kind == KIND_FREE) ? S_FREE : S_SCAN;
					end
				end
				S_FREE: state_q <= next_after;
				S_SCAN: begin
					if (res_en) begin
						state_q <= next_after;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// word pointer and bit offset of the item in flight
	always_ff @(posedge clk) begin
		if (req_fire) begin
			wp_q  <= mem_ra;
			off_q <= id_x[OFF_W-1:0];
		end else if (state_q == S_SCAN && !res_en) begin
			wp_q <= wp_q + AW'(1);
		end
	end

	// output register and holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((res_en || state_q == S_RESP) && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_en && slot_free) begin
			rsp_q <= res;
		end else if (state_q == S_RESP && slot_free) begin
			rsp_q <= hold_q;
		end
		if (res_en && !slot_free) begin
			hold_q <= res;
		end
	end

`ifndef SYNTH
	// a grant index only comes with a done status
	a_grant_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_DONE |-> rsp.granted_block == '0)
		else $error("granted_block nonzero on a failed result");

	// every map write ends the item in flight
	a_write_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_CLEAR |=> state_q == S_IDLE || state_q == S_RESP)
		else $error("map written in the middle of an item");

	// the scan never runs past the last word of the window
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> wp_q <= last_w)
		else $error("scan pointer beyond the last word");

	// the holding register is used only while the output register is full
	a_hold_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP |-> rsp_valid_q)
		else $error("result held while output register empty");
`endif

endmodule

`default_nettype wire
